// ===== rtl/fals_pkg.sv =====
package fals_pkg;

	localparam int Win    = 7;
	localparam int Lines  = 6;
	localparam int Radius = 3;
	localparam int Points = 16;
	localparam int PixW   = 8;

	// Configuration register indexes.
	localparam logic REG_THRESHOLD   = 1'b0;
	localparam logic REG_IMAGE_WIDTH = 1'b1;

	// Circle offsets relative to the centre, counterclockwise from straight below.
	localparam int CircleDx [Points] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
	localparam int CircleDy [Points] = '{3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1, 0, 1, 2, 3};

	typedef logic [PixW-1:0] pix_t;
	typedef logic [Lines*PixW-1:0] line_word_t;
	typedef logic [Win*PixW-1:0] column_t;
	typedef logic [Points-1:0] cls_mask_t;

	typedef struct packed {
		cls_mask_t bright;
		cls_mask_t dark;
	} cls_t;

endpackage

// ===== rtl/fast_arc_length_score.sv =====
// Channel     | Handshake              | Payload
// ------------+------------------------+-------------------------------------------
// pixel in    | in_valid / in_ready    | pixel, start_of_frame
// result out  | out_valid / out_ready  | score, valid_res, center_row, center_col
// config      | cfg_we                 | cfg_index, cfg_data
//
// Every pixel transfer yields one result transfer; while not stalled, a new pixel
// is taken every cycle. The six line stores share one memory word per column,
// read and written back once per pixel, which sets the one-pixel-per-cycle rate.
// Reset clears counters, window and stage valids; the line memory is not cleared.
// The whole pipeline stalls together while a result waits and out_ready is low.
module fast_arc_length_score #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [10:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  pixel,
	input  logic                        start_of_frame,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [4:0]                  score,
	output logic                        valid_res,
	output logic [$clog2(MAX_ROWS)-1:0] center_row,
	output logic [$clog2(MAX_WIDTH)-1:0] center_col
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > 11) ? WW + 1 : 12;
	localparam int Edge = 2 * fals_pkg::Radius;

	logic [7:0]  threshold_q;
	logic [10:0] image_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= 8'd20;
			image_width_q <= 11'd640;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fals_pkg::REG_THRESHOLD:   threshold_q   <= cfg_data[7:0];
				fals_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Width out of range is clamped to the window size or the memory depth.
	logic [EW-1:0] width_ext, eff_w;
	assign width_ext = EW'(image_width_q);
	always_comb begin
		priority if (width_ext < EW'(fals_pkg::Win)) begin
			eff_w = EW'(fals_pkg::Win);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
	end

	// The whole pipeline moves together unless a result waits at the output.
	logic en, accept;
	logic v_s1, v_s2, v_s3;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && in_ready;

	// Position of the next incoming pixel.
	logic [CW-1:0] col_q, col_cur;
	logic [RW-1:0] row_q, row_cur, row_inc_q, row_inc_cur;
	logic [EW-1:0] col_nxt;

	assign row_inc_q   = (row_q == RW'(MAX_ROWS - 1)) ? '0 : row_q + 1'b1;
	assign row_inc_cur = (row_cur == RW'(MAX_ROWS - 1)) ? '0 : row_cur + 1'b1;

	always_comb begin
		priority if (start_of_frame) begin
			col_cur = '0;
			row_cur = '0;
		end else if (EW'(col_q) >= eff_w) begin
			// The width shrank within the row: continue on the next row.
			col_cur = '0;
			row_cur = row_inc_q;
		end else begin
			col_cur = col_q;
			row_cur = row_q;
		end
	end
	assign col_nxt = EW'(col_cur) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_nxt >= eff_w) begin
				col_q <= '0;
				row_q <= row_inc_cur;
			end else begin
				col_q <= col_nxt[CW-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Stage 1: line memory word for this column arrives.
	fals_pkg::pix_t pix_s1;
	logic [CW-1:0]  col_s1, col_s2, col_s3, col_o;
	logic [RW-1:0]  row_s1, row_s2, row_s3, row_o;
	logic           ok_s1, ok_s2, ok_s3, ok_o;
	fals_pkg::line_word_t mem_rd, mem_wr;
	fals_pkg::column_t    column;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= accept;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= pixel;
			col_s1 <= col_cur;
			row_s1 <= row_cur;
			ok_s1  <= (row_cur >= RW'(Edge)) && (col_cur >= CW'(Edge));
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			ok_s2  <= ok_s1;
			col_s3 <= col_s2;
			row_s3 <= row_s2;
			ok_s3  <= ok_s2;
			col_o  <= col_s3;
			row_o  <= row_s3;
			ok_o   <= ok_s3;
		end
	end

	// The word shifts up one line and the new pixel enters as the newest line.
	assign mem_wr = {pix_s1, mem_rd[fals_pkg::Lines*fals_pkg::PixW-1:fals_pkg::PixW]};
	assign column = {pix_s1, mem_rd};

	fals_line_mem #(.Depth(MAX_WIDTH)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rd_addr (col_cur),
		.wr_en   (en && v_s1),
		.wr_addr (col_s1),
		.wr_data (mem_wr),
		.rd_data (mem_rd)
	);

	// Stage 2 shifts the window, stage 3 holds the classes, the output holds the score.
	fals_pkg::cls_t cls_s3;
	logic [4:0]     score_q;

	fals_window u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.shift     (en && v_s1),
		.column    (column),
		.threshold (threshold_q),
		.cls_s3    (cls_s3)
	);

	fals_arc u_arc (
		.clk     (clk),
		.en      (en),
		.cls     (cls_s3),
		.score_q (score_q)
	);

	assign valid_res  = ok_o;
	assign score      = ok_o ? score_q : '0;
	assign center_row = ok_o ? row_o - RW'(fals_pkg::Radius) : '0;
	assign center_col = ok_o ? col_o - CW'(fals_pkg::Radius) : '0;

endmodule

// ===== rtl/fals_line_mem.sv =====
module fals_line_mem #(
	parameter int Depth = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [$clog2(Depth)-1:0]      rd_addr,
	input  logic                          wr_en,
	input  logic [$clog2(Depth)-1:0]      wr_addr,
	input  fals_pkg::line_word_t          wr_data,
	output fals_pkg::line_word_t          rd_data
);

	fals_pkg::line_word_t mem [Depth];
	fals_pkg::line_word_t rd_q;
	fals_pkg::line_word_t fwd_data_q;
	logic                 fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// A read that meets a write to the same column in one cycle takes the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/fals_window.sv =====
module fals_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 shift,
	input  fals_pkg::column_t    column,
	input  logic [7:0]           threshold,
	output fals_pkg::cls_t       cls_s3
);

	fals_pkg::pix_t win_q [fals_pkg::Win][fals_pkg::Win];
	fals_pkg::cls_t cls_d;
	logic [8:0]     ctr;
	logic [8:0]     thr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < fals_pkg::Win; r++) begin
				for (int c = 0; c < fals_pkg::Win; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (shift) begin
			for (int r = 0; r < fals_pkg::Win; r++) begin
				for (int c = 0; c < fals_pkg::Win - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][fals_pkg::Win-1] <= column[r*fals_pkg::PixW +: fals_pkg::PixW];
			end
		end
	end

	assign ctr = {1'b0, win_q[fals_pkg::Radius][fals_pkg::Radius]};
	assign thr = {1'b0, threshold};

	// Brighter means p > c + t, darker means p + t < c; nine bits hold both sums.
	for (genvar i = 0; i < fals_pkg::Points; i++) begin : g_cls
		localparam int Row = fals_pkg::Radius + fals_pkg::CircleDy[i];
		localparam int Col = fals_pkg::Radius + fals_pkg::CircleDx[i];
		logic [8:0] p;
		assign p = {1'b0, win_q[Row][Col]};
		assign cls_d.bright[i] = p > (ctr + thr);
		assign cls_d.dark[i]   = (p + thr) < ctr;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cls_s3 <= cls_d;
		end
	end

endmodule

// ===== rtl/fals_arc.sv =====
module fals_arc (
	input  logic           clk,
	input  logic           en,
	input  fals_pkg::cls_t cls,
	output logic [4:0]     score_q
);

	localparam int P = fals_pkg::Points;

	fals_pkg::cls_mask_t same;
	logic [P-1:1]        has_run;
	logic [3:0]          max_run;
	logic [4:0]          score_d;

	// same[i]: pixel i and its counterclockwise neighbor share a non-neutral class.
	for (genvar i = 0; i < P; i++) begin : g_same
		assign same[i] = (cls.bright[i] & cls.bright[(i+1)%P]) |
			(cls.dark[i] & cls.dark[(i+1)%P]);
	end

	// has_run[L]: somewhere on the circle L consecutive links are set.
	for (genvar l = 1; l < P; l++) begin : g_len
		logic [P-1:0] at;
		for (genvar s = 0; s < P; s++) begin : g_start
			logic [l-1:0] seg;
			for (genvar k = 0; k < l; k++) begin : g_bit
				assign seg[k] = same[(s+k)%P];
			end
			assign at[s] = &seg;
		end
		assign has_run[l] = |at;
	end

	always_comb begin
		max_run = '0;
		for (int l = 1; l < P; l++) begin
			if (has_run[l]) begin
				max_run = 4'(l);
			end
		end
		if (!(|(cls.bright | cls.dark))) begin
			score_d = '0;
		end else if (&same) begin
			score_d = 5'(P);
		end else begin
			score_d = {1'b0, max_run} + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			score_q <= score_d;
		end
	end

endmodule

// ===== rtl/fals_checker.sv =====
module fals_checker #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_ROWS  = 2048
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [4:0]                   score,
	input logic                         valid_res,
	input logic [$clog2(MAX_ROWS)-1:0]  center_row,
	input logic [$clog2(MAX_WIDTH)-1:0] center_col
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("pixel taken while the output is stalled");

	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> score == 5'd0 && center_row == '0 && center_col == '0)
		else $error("border result carries nonzero fields");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && valid_res |-> score <= 5'd16 && center_row >= 3 && center_col >= 3)
		else $error("scored result out of range");

endmodule

bind fast_arc_length_score fals_checker #(
	.MAX_WIDTH (MAX_WIDTH),
	.MAX_ROWS  (MAX_ROWS)
) u_fals_checker (.*);
